[sv/vector_refraction_assert.svh]
// ----------------------------------------------------------------------------
// vector_refraction assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef VECTOR_REFRACTION_ASSERT_SVH
`define VECTOR_REFRACTION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector_refraction: implication check failed");
`define VR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vector_refraction: forbidden condition seen");
`else
`define VR_ASSERT_IMPL(lbl, ante, cons)
`define VR_ASSERT_NEVER(lbl, cond)
`endif
`endif

[sv/vr_pkg.sv]
// ----------------------------------------------------------------------------
// vr_pkg
// shared widths, latencies and word types of the refraction pipeline
// ----------------------------------------------------------------------------
package vr_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int RATIO_FRAC = 12;

  localparam int UW  = FRAC_BITS + 2;
  localparam int QB  = FRAC_BITS + 1;
  localparam int PW  = 2 * UW;
  localparam int CW  = FRAC_BITS + 3;
  localparam int SW  = FRAC_BITS + 4;
  localparam int PRW = FRAC_BITS + 9;
  localparam int SQW = FRAC_BITS + 18;
  localparam int LW  = FRAC_BITS + 20;
  localparam int RW  = 33 + UW;

  localparam int ISQ_STAGES = 32;
  localparam int NORM_LAT   = 5 + ISQ_STAGES + QB + 1;
  localparam int SNELL_LAT  = 7 + ISQ_STAGES + 2;
  localparam int TOTAL_LAT  = NORM_LAT + SNELL_LAT;

  localparam longint      ONE_FIX = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0] TMAX    = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
  localparam longint      SAT_HI  = 64'sd2147483647;
  localparam longint      SAT_LO  = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic [15:0]        index_ratio;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               degenerate;
  } out_word_t;

endpackage

[sv/vr_isqrt.sv]
// ----------------------------------------------------------------------------
// vr_isqrt
// pipelined floor square root of a 64-bit word, one result bit per stage
// ----------------------------------------------------------------------------
module vr_isqrt import vr_pkg::*; (
  input  logic        clk,
  input  logic [63:0] x,
  output logic [31:0] root
);

  logic [63:0] x_r   [ISQ_STAGES];
  logic [63:0] r_r   [ISQ_STAGES];
  logic [63:0] x_nxt [ISQ_STAGES];
  logic [63:0] r_nxt [ISQ_STAGES];

  always_comb begin
    logic [63:0] xi;
    logic [63:0] ri;
    logic [63:0] b;
    logic [63:0] s;
    for (int k = 0; k < ISQ_STAGES; k++) begin
      xi = (k == 0) ? x : x_r[(k == 0) ? 0 : k - 1];
      ri = (k == 0) ? 64'd0 : r_r[(k == 0) ? 0 : k - 1];
      b  = 64'd1 << (62 - 2 * k);
      s  = ri + b;
      if (xi >= s) begin
        x_nxt[k] = xi - s;
        r_nxt[k] = (ri >> 1) + b;
      end else begin
        x_nxt[k] = xi;
        r_nxt[k] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    r_r <= r_nxt;
  end

  assign root = r_r[ISQ_STAGES-1][31:0];

endmodule

[sv/vr_div.sv]
// ----------------------------------------------------------------------------
// vr_div
// pipelined restoring divider giving (num << FRAC_BITS) / den, num <= den
// ----------------------------------------------------------------------------
module vr_div import vr_pkg::*; (
  input  logic          clk,
  input  logic [31:0]   num,
  input  logic [31:0]   den,
  output logic [QB-1:0] q
);

  logic [31:0]   rem_r   [QB];
  logic [31:0]   den_r   [QB];
  logic [QB-1:0] q_r     [QB];
  logic [31:0]   rem_nxt [QB];
  logic [31:0]   den_nxt [QB];
  logic [QB-1:0] q_nxt   [QB];

  always_comb begin
    logic [31:0]   rem_i;
    logic [31:0]   den_i;
    logic [QB-1:0] q_i;
    logic          nb;
    logic [32:0]   trial;
    for (int j = 0; j < QB; j++) begin
      if (j == 0) begin
        rem_i = {1'b0, num[31:1]};
        den_i = den;
        q_i   = '0;
        nb    = num[0];
      end else begin
        rem_i = rem_r[j-1];
        den_i = den_r[j-1];
        q_i   = q_r[j-1];
        nb    = 1'b0;
      end
      trial      = {rem_i, nb};
      den_nxt[j] = den_i;
      if (trial >= {1'b0, den_i}) begin
        rem_nxt[j] = 32'(trial - {1'b0, den_i});
        q_nxt[j]   = {q_i[QB-2:0], 1'b1};
      end else begin
        rem_nxt[j] = trial[31:0];
        q_nxt[j]   = {q_i[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign q = q_r[QB-1];

endmodule

[sv/vr_norm.sv]
// ----------------------------------------------------------------------------
// vr_norm
// scales one Q8.24 vector to unit length: range shift, length, divide
// ----------------------------------------------------------------------------
module vr_norm import vr_pkg::*; (
  input  logic               clk,
  input  logic [2:0][31:0]   vec,
  output logic [2:0][UW-1:0] unit,
  output logic               zero
);

  typedef struct packed {
    logic [2:0][31:0] ms;
    logic [2:0]       neg;
    logic             zero;
  } isb_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } dsb_t;

  logic [2:0][31:0]   mag_c;
  logic [2:0]         neg_c;
  logic [2:0][31:0]   m1_r;
  logic [2:0]         neg1_r;
  logic               zero1_r;
  logic [31:0]        maxm_c;
  logic [5:0]         lz_c;
  logic [4:0]         sh2_r;
  logic [2:0][31:0]   m2_r;
  logic [2:0]         neg2_r;
  logic               zero2_r;
  logic [2:0][31:0]   ms3_r;
  logic [2:0]         neg3_r;
  logic               zero3_r;
  logic [2:0][63:0]   sq4_r;
  logic [2:0][31:0]   ms4_r;
  logic [2:0]         neg4_r;
  logic               zero4_r;
  logic [63:0]        len2_r;
  isb_t               isb5_r;
  isb_t               isb_r [ISQ_STAGES];
  logic [31:0]        len_c;
  dsb_t               dsb_r [QB];
  logic [2:0][QB-1:0] q_c;
  logic [2:0][UW-1:0] unit_r;
  logic               zero_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = vec[i][31];
      mag_c[i] = vec[i][31] ? (~vec[i] + 32'd1) : vec[i];
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= mag_c;
    neg1_r  <= neg_c;
    zero1_r <= (mag_c == '0);
  end

  always_comb begin
    maxm_c = m1_r[0];
    if (m1_r[1] > maxm_c) maxm_c = m1_r[1];
    if (m1_r[2] > maxm_c) maxm_c = m1_r[2];
    lz_c = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (maxm_c[i]) lz_c = 6'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    sh2_r   <= (lz_c == 6'd0) ? 5'd0 : 5'(lz_c - 6'd1);
    m2_r    <= m1_r;
    neg2_r  <= neg1_r;
    zero2_r <= zero1_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ms3_r[i] <= m2_r[i] << sh2_r;
    end
    neg3_r  <= neg2_r;
    zero3_r <= zero2_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq4_r[i] <= 64'(ms3_r[i]) * 64'(ms3_r[i]);
    end
    ms4_r   <= ms3_r;
    neg4_r  <= neg3_r;
    zero4_r <= zero3_r;
  end

  always_ff @(posedge clk) begin
    len2_r <= sq4_r[0] + sq4_r[1] + sq4_r[2];
  end

  always_ff @(posedge clk) begin
    isb5_r.ms   <= ms4_r;
    isb5_r.neg  <= neg4_r;
    isb5_r.zero <= zero4_r;
  end

  vr_isqrt u_isqrt (
    .clk  (clk),
    .x    (len2_r),
    .root (len_c)
  );

  always_ff @(posedge clk) begin
    isb_r[0] <= isb5_r;
    for (int k = 1; k < ISQ_STAGES; k++) begin
      isb_r[k] <= isb_r[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vr_div u_div (
      .clk (clk),
      .num (isb_r[ISQ_STAGES-1].ms[i]),
      .den (len_c),
      .q   (q_c[i])
    );
  end

  always_ff @(posedge clk) begin
    dsb_r[0].neg  <= isb_r[ISQ_STAGES-1].neg;
    dsb_r[0].zero <= isb_r[ISQ_STAGES-1].zero;
    for (int k = 1; k < QB; k++) begin
      dsb_r[k] <= dsb_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      unit_r[i] <= dsb_r[QB-1].neg[i] ? (~{1'b0, q_c[i]} + UW'(1)) : {1'b0, q_c[i]};
    end
    zero_r <= dsb_r[QB-1].zero;
  end

  assign unit = unit_r;
  assign zero = zero_r;

endmodule

[sv/vr_snell.sv]
// ----------------------------------------------------------------------------
// vr_snell
// cos term, perpendicular part, parallel root and saturated sum
// ----------------------------------------------------------------------------
module vr_snell import vr_pkg::*; (
  input  logic               clk,
  input  logic [2:0][UW-1:0] u,
  input  logic [2:0][UW-1:0] n,
  input  logic [15:0]        ratio,
  input  logic               deg,
  output out_word_t          word
);

  typedef struct packed {
    logic [2:0][PRW-1:0] perp;
    logic [2:0][UW-1:0]  n;
    logic                deg;
  } ssb_t;

  logic [2:0][PW-1:0]    pun1_r;
  logic [2:0][UW-1:0]    u1_r, n1_r;
  logic [15:0]           ratio1_r;
  logic                  deg1_r;
  logic signed [PW+1:0]  dot_c, cneg_c;
  logic signed [CW-1:0]  cos2_r;
  logic [2:0][UW-1:0]    u2_r, n2_r;
  logic [15:0]           ratio2_r;
  logic                  deg2_r;
  logic [2:0][CW+UW-1:0] cn3_r;
  logic [2:0][UW-1:0]    u3_r, n3_r;
  logic [15:0]           ratio3_r;
  logic                  deg3_r;
  logic [2:0][SW-1:0]    s4_r;
  logic [2:0][UW-1:0]    n4_r;
  logic [15:0]           ratio4_r;
  logic                  deg4_r;
  logic [2:0][PRW-1:0]   perp5_r;
  logic [2:0][UW-1:0]    n5_r;
  logic                  deg5_r;
  logic [2:0][SQW-1:0]   sq6_r;
  logic [2:0][PRW-1:0]   perp6_r;
  logic [2:0][UW-1:0]    n6_r;
  logic                  deg6_r;
  logic [LW-1:0]         lsq_c, t_c;
  logic [63:0]           t64_c;
  logic [63:0]           x7_r;
  ssb_t                  ssb7_r;
  ssb_t                  ssb_r [ISQ_STAGES];
  logic [31:0]           root_c;
  logic [2:0][RW-1:0]    par8_r;
  logic [2:0][PRW-1:0]   perp8_r;
  logic                  deg8_r;
  out_word_t             word_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pun1_r[i] <= PW'($signed(u[i]) * $signed(n[i]));
    end
    u1_r     <= u;
    n1_r     <= n;
    ratio1_r <= ratio;
    deg1_r   <= deg;
  end

  always_comb begin
    dot_c  = $signed(pun1_r[0]) + $signed(pun1_r[1]) + $signed(pun1_r[2]);
    cneg_c = -(dot_c >>> FRAC_BITS);
    if (cneg_c > ONE_FIX) cneg_c = (PW+2)'(ONE_FIX);
  end

  always_ff @(posedge clk) begin
    cos2_r   <= CW'(cneg_c);
    u2_r     <= u1_r;
    n2_r     <= n1_r;
    ratio2_r <= ratio1_r;
    deg2_r   <= deg1_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cn3_r[i] <= (CW+UW)'(cos2_r * $signed(n2_r[i]));
    end
    u3_r     <= u2_r;
    n3_r     <= n2_r;
    ratio3_r <= ratio2_r;
    deg3_r   <= deg2_r;
  end

  always_ff @(posedge clk) begin
    logic signed [CW+UW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum     = $signed(u3_r[i]) + ($signed(cn3_r[i]) >>> FRAC_BITS);
      s4_r[i] <= SW'(sum);
    end
    n4_r     <= n3_r;
    ratio4_r <= ratio3_r;
    deg4_r   <= deg3_r;
  end

  always_ff @(posedge clk) begin
    logic signed [SW+16:0] rp;
    for (int i = 0; i < 3; i++) begin
      rp         = $signed({1'b0, ratio4_r}) * $signed(s4_r[i]);
      perp5_r[i] <= PRW'(rp >>> RATIO_FRAC);
    end
    n5_r   <= n4_r;
    deg5_r <= deg4_r;
  end

  always_ff @(posedge clk) begin
    logic [PRW-1:0]   mag;
    logic [2*PRW-1:0] sq;
    for (int i = 0; i < 3; i++) begin
      mag      = perp5_r[i][PRW-1] ? (~perp5_r[i] + PRW'(1)) : perp5_r[i];
      sq       = (2*PRW)'(mag) * (2*PRW)'(mag);
      sq6_r[i] <= SQW'(sq >> FRAC_BITS);
    end
    perp6_r <= perp5_r;
    n6_r    <= n5_r;
    deg6_r  <= deg5_r;
  end

  always_comb begin
    lsq_c = LW'(sq6_r[0]) + LW'(sq6_r[1]) + LW'(sq6_r[2]);
    t_c   = (lsq_c >= LW'(ONE_FIX)) ? lsq_c - LW'(ONE_FIX) : LW'(ONE_FIX) - lsq_c;
    t64_c = 64'(t_c);
    if (t64_c > TMAX) t64_c = TMAX;
  end

  always_ff @(posedge clk) begin
    x7_r        <= t64_c << FRAC_BITS;
    ssb7_r.perp <= perp6_r;
    ssb7_r.n    <= n6_r;
    ssb7_r.deg  <= deg6_r;
  end

  vr_isqrt u_isqrt (
    .clk  (clk),
    .x    (x7_r),
    .root (root_c)
  );

  always_ff @(posedge clk) begin
    ssb_r[0] <= ssb7_r;
    for (int k = 1; k < ISQ_STAGES; k++) begin
      ssb_r[k] <= ssb_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      par8_r[i] <= RW'($signed({1'b0, root_c}) * $signed(ssb_r[ISQ_STAGES-1].n[i]));
    end
    perp8_r <= ssb_r[ISQ_STAGES-1].perp;
    deg8_r  <= ssb_r[ISQ_STAGES-1].deg;
  end

  always_ff @(posedge clk) begin
    logic signed [RW:0] d;
    logic [2:0][31:0]   o;
    for (int i = 0; i < 3; i++) begin
      d = $signed(perp8_r[i]) - ($signed(par8_r[i]) >>> FRAC_BITS);
      if (deg8_r) begin
        o[i] = 32'd0;
      end else if (d > SAT_HI) begin
        o[i] = 32'h7FFF_FFFF;
      end else if (d < SAT_LO) begin
        o[i] = 32'h8000_0000;
      end else begin
        o[i] = 32'(d);
      end
    end
    word_r.out_x      <= o[0];
    word_r.out_y      <= o[1];
    word_r.out_z      <= o[2];
    word_r.degenerate <= deg8_r;
  end

  assign word = word_r;

endmodule

[sv/vector_refraction.sv]
// ----------------------------------------------------------------------------
// vector_refraction
// refracts an incident ray about a surface normal, Q8.24 in and out
// ----------------------------------------------------------------------------
// a word is taken on in_data at each rising edge with start high and busy low;
// busy stays low, so a new ray may be issued every cycle
// each result appears on out_data for one cycle with out_valid high, after
// its word has passed both vr_norm units and vr_snell, in issue order
// throughput is one word per cycle: both length square roots, the three
// dividers per vector and the final root are fully pipelined, one result bit
// per stage, and these set the latency
// degenerate is set, with zero components, when either vector has zero length
// reset clears only the valid chain; words in flight are dropped
// the receiver has no hold-off: out_data must be taken when out_valid is high
// ----------------------------------------------------------------------------
`include "vector_refraction_assert.svh"

module vector_refraction import vr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);

  logic [TOTAL_LAT-1:0] vld_r;
  logic [TOTAL_LAT-1:0] vld_nxt;
  logic [15:0]          ratio_r [NORM_LAT];
  logic [2:0][UW-1:0]   unit_d_c, unit_n_c;
  logic                 zero_d_c, zero_n_c;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[TOTAL_LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ratio_r[0] <= in_data.index_ratio;
    for (int k = 1; k < NORM_LAT; k++) begin
      ratio_r[k] <= ratio_r[k-1];
    end
  end

  vr_norm u_norm_dir (
    .clk  (clk),
    .vec  ({in_data.dir_z, in_data.dir_y, in_data.dir_x}),
    .unit (unit_d_c),
    .zero (zero_d_c)
  );

  vr_norm u_norm_nrm (
    .clk  (clk),
    .vec  ({in_data.norm_z, in_data.norm_y, in_data.norm_x}),
    .unit (unit_n_c),
    .zero (zero_n_c)
  );

  vr_snell u_snell (
    .clk   (clk),
    .u     (unit_d_c),
    .n     (unit_n_c),
    .ratio (ratio_r[NORM_LAT-1]),
    .deg   (zero_d_c | zero_n_c),
    .word  (out_data)
  );

  assign out_valid = vld_r[TOTAL_LAT-1];

  `VR_ASSERT_IMPL(a_out_from_in, out_valid, $past(start && !busy, TOTAL_LAT))
  `VR_ASSERT_IMPL(a_deg_zero, out_valid && out_data.degenerate, out_data[96:1] == '0)
  `VR_ASSERT_NEVER(a_no_valid_after_reset, $rose(rst_n) && out_valid)

endmodule
